>>> sv/sirs_pkg.sv
// ----------------------------------------------------------------------------
// sirs_pkg: shared types and constants for the radix symbol converter
// Register map, alphabet limits, divider step size and the configuration
// bundle that travels from the register file to the front and back parts.
// ----------------------------------------------------------------------------
package sirs_pkg;

  // Parameter defaults
  localparam int DEF_MAX_RADIX  = 16;
  localparam int DEF_VALUE_BITS = 32;

  // Configuration port
  localparam int APB_AW = 5;
  localparam int APB_DW = 64;

  typedef enum logic [1:0] {
    REG_RADIX   = 2'd0,
    REG_SYM_LO  = 2'd1,
    REG_SYM_HI  = 2'd2
  } reg_idx_e;

  // Alphabet
  localparam int RAD_W     = 5;
  localparam int SYM_W     = 8;
  localparam int NUM_SYM   = 16;
  localparam int SYM_IDX_W = 4;

  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_FIRST = 8'd33;
  localparam logic [SYM_W-1:0] CH_LAST  = 8'd126;

  // Quotient bits resolved per divider cycle
  localparam int STEP_BITS = 8;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 2;

  typedef logic [NUM_SYM-1:0][SYM_W-1:0] sym_tab_t;

  typedef struct packed {
    logic [RAD_W-1:0] radix;
    sym_tab_t         syms;
    logic             alpha_ok;
  } cfg_t;

endpackage

>>> sv/sirs_cfg.sv
// ----------------------------------------------------------------------------
// sirs_cfg: configuration registers and alphabet check
// APB-style register file for radix and symbol bytes, plus the validity
// check of the alphabet currently in use.
// ----------------------------------------------------------------------------
module sirs_cfg #(
  parameter int MAX_RADIX = sirs_pkg::DEF_MAX_RADIX
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sirs_pkg::APB_AW-1:0] paddr,
  input  logic [sirs_pkg::APB_DW-1:0] pwdata,
  output logic [sirs_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output sirs_pkg::cfg_t              cfg_o
);
  import sirs_pkg::*;

  logic [RAD_W-1:0]  radix_q;
  logic [APB_DW-1:0] sym_lo_q;
  logic [APB_DW-1:0] sym_hi_q;
  sym_tab_t          syms;
  reg_idx_e          reg_idx;
  logic              wr_en;
  logic              alpha_ok;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[APB_AW-1:3]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign syms    = {sym_hi_q, sym_lo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q  <= '0;
      sym_lo_q <= '0;
      sym_hi_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RADIX:  radix_q  <= pwdata[RAD_W-1:0];
        REG_SYM_LO: sym_lo_q <= pwdata;
        REG_SYM_HI: sym_hi_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RADIX:  prdata = APB_DW'(radix_q);
      REG_SYM_LO: prdata = sym_lo_q;
      REG_SYM_HI: prdata = sym_hi_q;
      default:    prdata = '0;
    endcase
  end

  // Only the first radix symbols count: printable, no sign chars, no repeats
  always_comb begin
    alpha_ok = (radix_q >= RAD_W'(2)) && (radix_q <= RAD_W'(MAX_RADIX));
    for (int i = 0; i < MAX_RADIX; i++) begin
      if (RAD_W'(i) < radix_q) begin
        if (syms[i] < CH_FIRST || syms[i] > CH_LAST ||
            syms[i] == CH_PLUS || syms[i] == CH_MINUS) begin
          alpha_ok = 1'b0;
        end
        for (int j = i + 1; j < MAX_RADIX; j++) begin
          if (RAD_W'(j) < radix_q && syms[i] == syms[j]) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  assign cfg_o.radix    = radix_q;
  assign cfg_o.syms     = syms;
  assign cfg_o.alpha_ok = alpha_ok;

endmodule

>>> sv/sirs_front.sv
// ----------------------------------------------------------------------------
// sirs_front: input stage
// Takes items, drops them when the alphabet is invalid, splits the value
// into sign and magnitude and holds the result for the command queue.
// ----------------------------------------------------------------------------
module sirs_front #(
  parameter int VALUE_BITS = sirs_pkg::DEF_VALUE_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic signed [VALUE_BITS-1:0] value_i,
  input  logic                         alpha_ok_i,
  output logic                         cmd_valid_o,
  output logic [VALUE_BITS:0]          cmd_o,
  input  logic                         cmd_ready_i
);
  logic                  stg_valid_q;
  logic [VALUE_BITS:0]   stg_cmd_q;
  logic [VALUE_BITS-1:0] value_u;
  logic [VALUE_BITS-1:0] mag;
  logic                  neg;
  logic                  accept;

  assign value_u = value_i;
  assign neg     = value_u[VALUE_BITS-1];
  // Most negative value maps onto itself, which is its true unsigned magnitude
  assign mag     = neg ? (~value_u + VALUE_BITS'(1)) : value_u;

  assign full   = stg_valid_q && !cmd_ready_i;
  assign accept = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      stg_cmd_q   <= '0;
    end else if (accept) begin
      stg_valid_q <= alpha_ok_i;
      stg_cmd_q   <= {neg, mag};
    end else if (cmd_ready_i) begin
      stg_valid_q <= 1'b0;
    end
  end

  assign cmd_valid_o = stg_valid_q;
  assign cmd_o       = stg_cmd_q;

endmodule

>>> sv/sirs_cmdq.sv
// ----------------------------------------------------------------------------
// sirs_cmdq: command queue
// Short FIFO of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module sirs_cmdq #(
  parameter int WIDTH = sirs_pkg::DEF_VALUE_BITS + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_pop_i,
  output logic [WIDTH-1:0] rd_data_o
);
  import sirs_pkg::*;

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  logic [WIDTH-1:0] slot_q [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready_o = cnt_q != CNT_W'(CMDQ_DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_pop_i && rd_valid_o;
  assign rd_data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

>>> sv/sirs_back.sv
// ----------------------------------------------------------------------------
// sirs_back: digit engine and symbol emitter
// Iterative divider peels digits into a stack, then the stack is read back
// most significant first and mapped through the alphabet.
// ----------------------------------------------------------------------------
module sirs_back #(
  parameter int MAX_RADIX  = sirs_pkg::DEF_MAX_RADIX,
  parameter int VALUE_BITS = sirs_pkg::DEF_VALUE_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  logic [VALUE_BITS:0]        cmd_i,
  output logic                       cmd_pop_o,
  input  sirs_pkg::cfg_t             cfg_i,
  output logic                       res_empty_o,
  input  logic                       res_pop_i,
  output logic [sirs_pkg::SYM_W-1:0] symbol_o,
  output logic                       last_o
);
  import sirs_pkg::*;

  localparam int DIG_W   = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  localparam int DIV_CYC = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int DIV_W   = DIV_CYC * STEP_BITS;
  localparam int CYC_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
  localparam int IDX_W   = $clog2(VALUE_BITS);
  localparam int CMP_W   = RAD_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_EMIT
  } state_e;

  state_e           state_q;
  logic [DIV_W-1:0] div_q;
  logic [DIV_W-1:0] div_d;
  logic [DIG_W-1:0] rem_q;
  logic [DIG_W-1:0] rem_d;
  logic [CYC_W-1:0] cyc_q;
  logic [IDX_W-1:0] idx_q;
  logic             neg_q;
  logic             out_valid_q;
  logic [SYM_W-1:0] out_sym_q;
  logic             out_last_q;

  logic [DIG_W-1:0] stack_mem [VALUE_BITS];
  logic [DIG_W-1:0] rd_q;

  logic             slot_free;
  logic             out_load;
  logic             digit_done;
  logic             div_done;
  logic             stack_wr;
  logic             stack_rd;

  // Restoring division, STEP_BITS quotient bits per cycle; quotient shifts
  // into div_q from the bottom as the dividend leaves at the top
  always_comb begin
    logic [DIV_W-1:0] d;
    logic [DIG_W-1:0] r;
    logic [CMP_W-1:0] trial;
    d = div_q;
    r = rem_q;
    for (int k = 0; k < STEP_BITS; k++) begin
      trial = CMP_W'({r, d[DIV_W-1]});
      if (trial >= CMP_W'(cfg_i.radix)) begin
        r = DIG_W'(trial - CMP_W'(cfg_i.radix));
        d = {d[DIV_W-2:0], 1'b1};
      end else begin
        r = trial[DIG_W-1:0];
        d = {d[DIV_W-2:0], 1'b0};
      end
    end
    div_d = d;
    rem_d = r;
  end

  assign slot_free  = !out_valid_q || res_pop_i;
  assign out_load   = slot_free && ((state_q == ST_SIGN) || (state_q == ST_EMIT));
  assign digit_done = cyc_q == CYC_W'(DIV_CYC - 1);
  assign div_done   = (div_d == '0) || (idx_q == IDX_W'(VALUE_BITS - 1));
  assign stack_wr   = (state_q == ST_DIV) && digit_done;
  assign stack_rd   = state_q == ST_READ;
  assign cmd_pop_o  = (state_q == ST_IDLE) && cmd_valid_i;

  always_ff @(posedge clk_i) begin
    if (stack_wr) begin
      stack_mem[idx_q] <= rem_d;
    end
    if (stack_rd) begin
      rd_q <= stack_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_q       <= '0;
      rem_q       <= '0;
      cyc_q       <= '0;
      idx_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_sym_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // Result register refills on the same edge it is popped
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            div_q   <= DIV_W'(cmd_i[VALUE_BITS-1:0]);
            neg_q   <= cmd_i[VALUE_BITS];
            rem_q   <= '0;
            cyc_q   <= '0;
            idx_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          div_q <= div_d;
          if (digit_done) begin
            rem_q <= '0;
            cyc_q <= '0;
            if (div_done) begin
              state_q <= neg_q ? ST_SIGN : ST_READ;
            end else begin
              idx_q <= idx_q + IDX_W'(1);
            end
          end else begin
            rem_q <= rem_d;
            cyc_q <= cyc_q + CYC_W'(1);
          end
        end
        ST_SIGN: begin
          if (slot_free) begin
            out_sym_q   <= CH_MINUS;
            out_last_q  <= 1'b0;
            state_q     <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_sym_q   <= cfg_i.syms[SYM_IDX_W'(rd_q)];
            out_last_q  <= idx_q == '0;
            if (idx_q == '0) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_q - IDX_W'(1);
              state_q <= ST_READ;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_empty_o = !out_valid_q;
  assign symbol_o    = out_sym_q;
  assign last_o      = out_last_q;

endmodule

>>> sv/signed_integer_to_radix_symbols_core.sv
// ----------------------------------------------------------------------------
// signed_integer_to_radix_symbols_core: signed integer to radix text
// Converts a signed value into its text in a configured radix and alphabet:
// optional minus sign, then digits most significant first, last marked.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  --------  ---------  ------------------------  -----------------------------
//  input     in         push / full               value_i
//  result    out        empty / pop               symbol_o, last_o
//  config    in/out     psel, penable, pwrite,    paddr, pwdata, prdata
//                       pready (always high)      (radix @0, sym lo @8, hi @16)
//
//  Divider: resolves 8 quotient bits per cycle; each digit goes into the digit
//  stack memory, and every digit is read back from it through a registered
//  read state (ST_READ) before its symbol is emitted, after an optional minus.
//  Reset: asynchronous, active low; registers clear to zero, radix 0 means an
//  invalid alphabet, so items are taken and dropped until configured.
//  Stalls: front stage plus a two-entry command queue keep taking items while
//  the back part converts; a held result stalls the back part, then the queue and front.
//
module signed_integer_to_radix_symbols_core #(
  parameter int MAX_RADIX  = sirs_pkg::DEF_MAX_RADIX,
  parameter int VALUE_BITS = sirs_pkg::DEF_VALUE_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input items
  input  logic                         push,
  output logic                         full,
  input  logic signed [VALUE_BITS-1:0] value_i,
  // result items
  output logic                         empty,
  input  logic                         pop,
  output logic [sirs_pkg::SYM_W-1:0]   symbol_o,
  output logic                         last_o,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sirs_pkg::APB_AW-1:0]  paddr,
  input  logic [sirs_pkg::APB_DW-1:0]  pwdata,
  output logic [sirs_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import sirs_pkg::*;

  cfg_t                cfg;
  logic                fr_valid;
  logic [VALUE_BITS:0] fr_cmd;
  logic                q_ready;
  logic                q_valid;
  logic [VALUE_BITS:0] q_cmd;
  logic                q_pop;

  // Registers and the alphabet check (combinational from the registers; the user
  // must change them only while the block is idle, which the block does not enforce)
  sirs_cfg #(
    .MAX_RADIX (MAX_RADIX)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Front: accept, drop on bad alphabet, split sign and magnitude
  sirs_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .value_i     (value_i),
    .alpha_ok_i  (cfg.alpha_ok),
    .cmd_valid_o (fr_valid),
    .cmd_o       (fr_cmd),
    .cmd_ready_i (q_ready)
  );

  // Decoupling queue: {negative, magnitude}
  sirs_cmdq #(
    .WIDTH (VALUE_BITS + 1)
  ) u_cmdq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (q_ready),
    .wr_data_i  (fr_cmd),
    .rd_valid_o (q_valid),
    .rd_pop_i   (q_pop),
    .rd_data_o  (q_cmd)
  );

  // Back: digit extraction, stack, symbol emission into the result register
  sirs_back #(
    .MAX_RADIX  (MAX_RADIX),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .cfg_i       (cfg),
    .res_empty_o (empty),
    .res_pop_i   (pop),
    .symbol_o    (symbol_o),
    .last_o      (last_o)
  );

endmodule

>>> sim/signed_integer_to_radix_symbols_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_integer_to_radix_symbols_core_tb: self-checking bench for the converter
// Loads alphabets over the register port, pushes signed values through the
// input queue and checks every emitted symbol and its last flag against an
// in-bench model of the radix conversion, with random idling on both sides.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_symbols_core_tb;
  import sirs_pkg::*;

  localparam int VALUE_W       = 32;
  localparam int MAX_RADIX     = 16;
  localparam int IDLE_PCT      = 22;
  localparam int HOLD_CYCLES   = 500;    // long receiver stall, fills the block
  localparam int SETTLE_CYCLES = 800;    // a few worst-case items
  localparam int STALL_LIMIT   = 20000;  // cycles with no handshake at all

  // Decimal alphabet; unused digit slots hold junk that must be ignored
  localparam logic [63:0] DEC_LO = 64'h3736_3534_3332_3130;
  localparam logic [63:0] DEC_HI = 64'h00FF_2B2D_7F39_3938;
  // Radix 16 alphabet using both ends of the legal range: "!0123456789ABCD~"
  localparam logic [63:0] HEX_LO = 64'h3635_3433_3231_3021;
  localparam logic [63:0] HEX_HI = 64'h7E44_4342_4139_3837;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             is_last;
  } symbol_item_t;

  // DUT signals, all known from time zero
  logic                      clk_i   = 1'b0;
  logic                      rst_ni  = 1'b0;
  logic                      push    = 1'b0;
  logic                      full;
  logic signed [VALUE_W-1:0] value_i = '0;
  logic                      empty;
  logic                      pop     = 1'b0;
  logic [SYM_W-1:0]          symbol_o;
  logic                      last_o;
  logic                      psel    = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite  = 1'b0;
  logic [APB_AW-1:0]         paddr   = '0;
  logic [APB_DW-1:0]         pwdata  = '0;
  logic [APB_DW-1:0]         prdata;
  logic                      pready;

  // Register shadows used by the symbol predictor
  logic [RAD_W-1:0]          cfg_radix  = '0;
  logic [63:0]               cfg_sym_lo = '0;
  logic [63:0]               cfg_sym_hi = '0;

  // Converter state as the predictor sees it
  logic                      conv_negative    = 1'b0;
  int unsigned               conv_digit_count = 0;

  logic signed [VALUE_W-1:0] value_pending_q [$];  // values not yet taken by the DUT
  symbol_item_t              symbol_expect_q [$];  // symbols still owed by the DUT
  symbol_item_t              want;

  logic                      value_taken = 1'b0;   // item on value_i went in last edge
  bit                        no_idle     = 1'b0;
  int unsigned               hold_req_cnt  = 0;
  int unsigned               hold_done_cnt = 0;
  int unsigned               hold_left     = 0;
  int unsigned               stall_cycles  = 0;

  int unsigned               fail_cnt        = 0;
  int unsigned               values_accepted = 0;
  int unsigned               values_dropped  = 0;
  int unsigned               symbols_checked = 0;
  int unsigned               alphabets_run   = 0;

  signed_integer_to_radix_symbols_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .value_i (value_i),
    .empty   (empty),
    .pop     (pop),
    .symbol_o(symbol_o),
    .last_o  (last_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Symbol byte for one digit value, low word holds digits 0..7
  function automatic logic [SYM_W-1:0] sym_of(logic [3:0] d);
    if (d < 4'd8) return cfg_sym_lo[8*d +: 8];
    return cfg_sym_hi[8*(d-4'd8) +: 8];
  endfunction

  // Radix in range, each used symbol printable, not a sign, and unique
  function automatic bit alphabet_ok();
    logic [SYM_W-1:0] s;
    if (cfg_radix < 2 || cfg_radix > MAX_RADIX) return 1'b0;
    for (int i = 0; i < cfg_radix; i++) begin
      s = sym_of(4'(i));
      if (s < CH_FIRST || s > CH_LAST || s == CH_PLUS || s == CH_MINUS) return 1'b0;
      for (int j = i + 1; j < cfg_radix; j++)
        if (sym_of(4'(j)) == s) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Queue the text of one value: optional minus, digits MSD first, last flagged
  function automatic void predict_text(logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] mag;
    logic [3:0]         digits [$];
    if (!alphabet_ok()) begin
      values_dropped++;  // bad alphabet: nothing out, state untouched
      return;
    end
    conv_negative = v[VALUE_W-1];
    // unsigned negate also gives the true magnitude of the most negative value
    mag = conv_negative ? (VALUE_W'(0) - v) : v;
    do begin
      digits.push_back(4'(mag % cfg_radix));
      mag = mag / cfg_radix;
    end while (mag != 0);
    conv_digit_count = digits.size();
    if (conv_negative) symbol_expect_q.push_back('{symbol: CH_MINUS, is_last: 1'b0});
    for (int k = digits.size() - 1; k >= 0; k--)
      symbol_expect_q.push_back('{symbol: sym_of(digits[k]), is_last: (k == 0)});
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: sample handshakes at the rising edge, predict and compare
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      value_taken <= 1'b0;
    end else begin
      value_taken <= push && !full;
      if (push && !full) begin
        values_accepted++;
        predict_text(value_i);
      end
      if (pop && !empty) begin
        if (symbol_expect_q.size() == 0) begin
          $error("unexpected item: symbol %h last %b", symbol_o, last_o);
          fail_cnt++;
        end else begin
          want = symbol_expect_q.pop_front();
          symbols_checked++;
          if (symbol_o !== want.symbol) begin
            $error("symbol: expected %h, got %h", want.symbol, symbol_o);
            fail_cnt++;
          end
          if (last_o !== want.is_last) begin
            $error("last: expected %b, got %b", want.is_last, last_o);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: no handshake of any kind for too long ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (psel && penable))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver: offers the oldest pending value, idles at random
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (value_taken) void'(value_pending_q.pop_front());
      if (value_pending_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
        push    <= 1'b1;
        value_i <= value_pending_q[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: random pops, plus long hold-offs on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_done_cnt != hold_req_cnt) begin
      hold_done_cnt++;
      hold_left = HOLD_CYCLES;
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Two-phase register write; pready is sampled before closing the access
  task automatic write_reg(reg_idx_e idx, logic [APB_DW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx) << 3;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_RADIX:  cfg_radix  = data[RAD_W-1:0];
      REG_SYM_LO: cfg_sym_lo = data;
      REG_SYM_HI: cfg_sym_hi = data;
      default: ;
    endcase
  endtask

  // Sender pause: everything taken and answered, then let dropped items clear
  task automatic drain_results();
    while (value_pending_q.size() != 0 || push || symbol_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Radix write carries junk above bit 4 since only the low bits are kept
  task automatic load_alphabet(logic [RAD_W-1:0] r, logic [63:0] lo, logic [63:0] hi);
    drain_results();
    write_reg(REG_RADIX, ({$urandom, $urandom} & ~64'h1F) | 64'(r));
    write_reg(REG_SYM_LO, lo);
    write_reg(REG_SYM_HI, hi);
    alphabets_run++;
  endtask

  // Random distinct legal symbols for the first r digits, junk in the rest
  task automatic build_alphabet(int r, output logic [63:0] lo, output logic [63:0] hi);
    bit         used [256];
    logic [7:0] c;
    for (int i = 0; i < NUM_SYM; i++) begin
      if (i < r) begin
        do c = 8'($urandom_range(CH_FIRST, CH_LAST));
        while (c == CH_PLUS || c == CH_MINUS || used[c]);
        used[c] = 1'b1;
      end else begin
        c = 8'($urandom);
      end
      if (i < 8) lo[8*i +: 8] = c;
      else       hi[8*(i-8) +: 8] = c;
    end
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom;
      4, 5:       v = $urandom_range(300);
      6:          v = -$urandom_range(300);
      7:          v = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default:    v = ($urandom >> $urandom_range(31)) ^ {VALUE_W{$urandom_range(1) == 1}};
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int          r;
    int          p;
    int          q;
    logic [7:0]  bad;
    logic [63:0] lo;
    logic [63:0] hi;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Out of reset radix is 0: items are taken and dropped
    value_pending_q.push_back(123);
    value_pending_q.push_back(-5);

    // Decimal: zero, ones, digit carry and both extremes
    load_alphabet(5'd10, DEC_LO, DEC_HI);
    value_pending_q.push_back(0);
    value_pending_q.push_back(1);
    value_pending_q.push_back(-1);
    value_pending_q.push_back(9);
    value_pending_q.push_back(10);
    value_pending_q.push_back(32'h7FFF_FFFF);
    value_pending_q.push_back(32'h8000_0000);

    // Binary: most negative gives a minus and 32 digits, the longest text
    load_alphabet(5'd2, 64'h2D2B_0000_FF20_3130, 64'h3030_3030_3030_3030);
    value_pending_q.push_back(32'h8000_0000);
    value_pending_q.push_back(-1);
    value_pending_q.push_back(32'h7FFF_FFFF);
    value_pending_q.push_back(32'h5555_5555);

    // Radix 16 with symbols 33 and 126 in use
    load_alphabet(5'd16, HEX_LO, HEX_HI);
    value_pending_q.push_back(32'h7FFF_FFFF);
    value_pending_q.push_back(32'h8000_0000);
    value_pending_q.push_back(32'hDEAD_BEEF);
    value_pending_q.push_back(15);

    // Bad alphabets, one value each, nothing may come out
    load_alphabet(5'd1, DEC_LO, DEC_HI);                       // radix too small
    value_pending_q.push_back(7);
    load_alphabet(5'd17, HEX_LO, HEX_HI);                      // radix too large
    value_pending_q.push_back(-7);
    load_alphabet(5'd31, HEX_LO, HEX_HI);
    value_pending_q.push_back(32'h8000_0000);
    load_alphabet(5'd10, DEC_LO, {DEC_HI[63:16], 8'h20, 8'h38});  // space
    value_pending_q.push_back(42);
    load_alphabet(5'd10, DEC_LO, {DEC_HI[63:16], 8'h7F, 8'h38});  // DEL
    value_pending_q.push_back(42);
    load_alphabet(5'd10, DEC_LO, {DEC_HI[63:16], CH_PLUS, 8'h38});
    value_pending_q.push_back(42);
    load_alphabet(5'd10, {DEC_LO[63:8], CH_MINUS}, DEC_HI);
    value_pending_q.push_back(42);
    load_alphabet(5'd10, DEC_LO, {DEC_HI[63:16], 8'h30, 8'h38});  // repeats digit 0
    value_pending_q.push_back(42);

    // Random alphabets. Phase 2 stalls the receiver in radix 2 while negative
    // values keep coming; phase 3 runs with no idling; phase 5 opens with a
    // random bad alphabet.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 5) begin
        r = $urandom_range(2, 16);
        build_alphabet(r, lo, hi);
        p = $urandom_range(r - 1);
        q = (p + 1 + $urandom_range(r - 2)) % r;
        case ($urandom_range(4))
          0: r = $urandom_range(1);
          1: r = $urandom_range(17, 31);
          2: bad = 8'($urandom_range(0, 32));
          3: bad = 8'($urandom_range(127, 255));
          default: bad = (q < 8) ? lo[8*q +: 8] : hi[8*(q-8) +: 8];
        endcase
        if (r >= 2 && r <= 16) begin
          if (p < 8) lo[8*p +: 8] = bad;
          else       hi[8*(p-8) +: 8] = bad;
        end
        load_alphabet(5'(r), lo, hi);
        repeat (4) value_pending_q.push_back(pick_value());
      end
      r = (ph == 0 || ph == 2) ? 2 : (ph == 1) ? 16 : $urandom_range(2, 16);
      build_alphabet(r, lo, hi);
      load_alphabet(5'(r), lo, hi);
      no_idle = (ph == 3);
      if (ph == 2) hold_req_cnt++;
      for (int i = 0; i < 25; i++)
        value_pending_q.push_back((ph == 2) ? {1'b1, 31'($urandom)} : pick_value());
    end

    drain_results();
    $display("%0d values accepted (%0d on bad alphabets), %0d symbols checked",
             values_accepted, values_dropped, symbols_checked);
    $display("%0d alphabet loads: radix 2..16, bad alphabets, long result stall",
             alphabets_run);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/sirs_pkg.sv
sv/sirs_cfg.sv
sv/sirs_front.sv
sv/sirs_cmdq.sv
sv/sirs_back.sv
sv/signed_integer_to_radix_symbols_core.sv
sim/signed_integer_to_radix_symbols_core_tb.sv
